// ----- design/tftpc_pkg.sv -----
// Types and constants shared by the TFTP transfer controller.
// No dependencies; imported by tftpc_ctrl, tftp_server_transfer_control_top and the testbench files.
`default_nettype none

package tftpc_pkg;

    // Transfer phases
    typedef enum logic [2:0] {
        PH_INIT    = 3'd0,
        PH_WAIT_RQ = 3'd1,
        PH_RD_SEND = 3'd2,
        PH_RD_ACK  = 3'd3,
        PH_WR_ACK  = 3'd4,
        PH_WR_DATA = 3'd5
    } t_phase;

    // Received opcodes
    localparam logic [15:0] OP_RRQ  = 16'd1;
    localparam logic [15:0] OP_WRQ  = 16'd2;
    localparam logic [15:0] OP_DATA = 16'd3;
    localparam logic [15:0] OP_ACK  = 16'd4;

    // Mode codes from the front end
    localparam logic [1:0] MODE_OCTET    = 2'd0;
    localparam logic [1:0] MODE_NETASCII = 2'd1;

    // Packet kinds to send
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_ACK  = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    // TFTP error codes
    localparam logic [2:0] ERR_OTHER     = 3'd0;
    localparam logic [2:0] ERR_NO_FILE   = 3'd1;
    localparam logic [2:0] ERR_ACCESS    = 3'd2;
    localparam logic [2:0] ERR_DISK_FULL = 3'd3;
    localparam logic [2:0] ERR_ILLEGAL   = 3'd4;

    // Port commands
    localparam logic [1:0] PORT_NONE   = 2'd0;
    localparam logic [1:0] PORT_LISTEN = 2'd1;
    localparam logic [1:0] PORT_PEER   = 2'd2;

    // Register map (word index)
    localparam logic REG_LISTEN_PORT = 1'b0;
    localparam logic [15:0] LISTEN_PORT_RESET = 16'd69;

    // Protocol sizes
    localparam int unsigned BLOCK_BYTES   = 512;
    localparam int unsigned NAME_MAX      = 128;
    localparam int unsigned HDR_BYTES     = 1 + 1 + 1 + 1;
    localparam int unsigned MIN_REQ_BYTES = 4;
    localparam int unsigned ACK_BYTES     = 4;

    typedef struct packed {
        logic [10:0] rx_length;
        logic [15:0] rx_opcode;
        logic [15:0] rx_block;
        logic [7:0]  name_length;
        logic [1:0]  transfer_mode;
        logic        file_ok;
        logic [9:0]  read_length;
        logic [9:0]  write_length;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  tx_kind;
        logic [15:0] tx_block;
        logic [2:0]  tx_error;
        logic [9:0]  tx_data_length;
        logic        file_close;
        logic [1:0]  port_action;
        logic [2:0]  phase_now;
    } t_out_item;

endpackage

`default_nettype wire

// ----- design/tftpc_ctrl.sv -----
// Transfer state (phase, block counter, last-block flag) and per-item decision.
// Depends on tftpc_pkg.
`default_nettype none

module tftpc_ctrl
    import tftpc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_adv,
    input  wire t_in_item  i_item,
    output t_out_item      o_res
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_block_counter, n_block_counter;
    logic        r_last_block, n_last_block;

    logic [15:0] w_cnt_inc;
    logic [9:0]  w_rd_len;
    logic        w_rd_last;
    logic [10:0] w_data_len;
    logic        w_req_act, w_op_bad, w_name_bad, w_mode_bad, w_req_go;
    logic        w_ack_match, w_data_act, w_wr_fit, w_wr_short;

    assign w_cnt_inc  = r_block_counter + 16'd1;
    assign w_rd_len   = (i_item.read_length > 10'(BLOCK_BYTES)) ? 10'(BLOCK_BYTES)
                                                                : i_item.read_length;
    assign w_rd_last  = w_rd_len < 10'(BLOCK_BYTES);
    assign w_data_len = i_item.rx_length - 11'(HDR_BYTES);

    assign w_req_act  = i_item.rx_length > 11'(MIN_REQ_BYTES);
    assign w_op_bad   = (i_item.rx_opcode != OP_RRQ) && (i_item.rx_opcode != OP_WRQ);
    assign w_name_bad = (i_item.name_length == 8'd0) ||
                        (i_item.name_length > 8'(NAME_MAX));
    assign w_mode_bad = (i_item.transfer_mode != MODE_OCTET) &&
                        (i_item.transfer_mode != MODE_NETASCII);
    assign w_req_go   = !w_op_bad && !w_name_bad && !w_mode_bad && i_item.file_ok;

    assign w_ack_match = (i_item.rx_length == 11'(ACK_BYTES)) &&
                         (i_item.rx_opcode == OP_ACK) &&
                         (i_item.rx_block == r_block_counter);
    assign w_data_act  = (i_item.rx_length >= 11'(HDR_BYTES)) &&
                         (i_item.rx_length <= 11'(BLOCK_BYTES + HDR_BYTES)) &&
                         (i_item.rx_opcode == OP_DATA);
    assign w_wr_fit    = {1'b0, i_item.write_length} == w_data_len;
    assign w_wr_short  = w_data_len < 11'(BLOCK_BYTES);

    // Next state
    always_comb begin
        n_phase         = r_phase;
        n_block_counter = r_block_counter;
        n_last_block    = r_last_block;
        case (r_phase)
            PH_WAIT_RQ: begin
                if (w_req_act && w_req_go) begin
                    if (i_item.rx_opcode == OP_RRQ) begin
                        n_block_counter = w_cnt_inc;
                        n_last_block    = w_rd_last;
                        n_phase         = PH_RD_ACK;
                    end else begin
                        n_phase = r_last_block ? PH_INIT : PH_WR_DATA;
                    end
                end
            end
            PH_RD_SEND: begin
                n_block_counter = w_cnt_inc;
                n_last_block    = w_rd_last;
                n_phase         = PH_RD_ACK;
            end
            PH_RD_ACK: begin
                if (w_ack_match) begin
                    n_phase = r_last_block ? PH_INIT : PH_RD_SEND;
                end
            end
            PH_WR_ACK: begin
                n_phase = r_last_block ? PH_INIT : PH_WR_DATA;
            end
            PH_WR_DATA: begin
                if (w_data_act) begin
                    n_block_counter = i_item.rx_block;
                    if (w_wr_fit) begin
                        if (w_wr_short) begin
                            n_last_block = 1'b1;
                        end
                        n_phase = (w_wr_short || r_last_block) ? PH_INIT : PH_WR_DATA;
                    end else begin
                        n_phase = PH_INIT;
                    end
                end
            end
            default: begin
                n_block_counter = 16'd0;
                n_last_block    = 1'b0;
                n_phase         = PH_WAIT_RQ;
            end
        endcase
    end

    // Result
    always_comb begin
        o_res           = '0;
        o_res.phase_now = n_phase;
        case (r_phase)
            PH_WAIT_RQ: begin
                if (w_req_act) begin
                    if (w_op_bad) begin
                        o_res.tx_kind  = KIND_ERR;
                        o_res.tx_error = ERR_ILLEGAL;
                    end else if (w_name_bad) begin
                        o_res.tx_kind  = KIND_ERR;
                        o_res.tx_error = ERR_OTHER;
                    end else if (w_mode_bad) begin
                        o_res.tx_kind  = KIND_ERR;
                        o_res.tx_error = ERR_ILLEGAL;
                    end else if (!i_item.file_ok) begin
                        o_res.tx_kind  = KIND_ERR;
                        o_res.tx_error = (i_item.rx_opcode == OP_RRQ) ? ERR_NO_FILE
                                                                      : ERR_ACCESS;
                    end else begin
                        o_res.port_action = PORT_PEER;
                        if (i_item.rx_opcode == OP_RRQ) begin
                            o_res.tx_kind        = KIND_DATA;
                            o_res.tx_block       = w_cnt_inc;
                            o_res.tx_data_length = w_rd_len;
                            o_res.file_close     = w_rd_last;
                        end else begin
                            o_res.tx_kind  = KIND_ACK;
                            o_res.tx_block = r_block_counter;
                        end
                    end
                end
            end
            PH_RD_SEND: begin
                o_res.tx_kind        = KIND_DATA;
                o_res.tx_block       = w_cnt_inc;
                o_res.tx_data_length = w_rd_len;
                o_res.file_close     = w_rd_last;
            end
            PH_RD_ACK: begin
                o_res.tx_kind = KIND_NONE;
            end
            PH_WR_ACK: begin
                o_res.tx_kind  = KIND_ACK;
                o_res.tx_block = r_block_counter;
            end
            PH_WR_DATA: begin
                if (w_data_act) begin
                    if (w_wr_fit) begin
                        o_res.tx_kind    = KIND_ACK;
                        o_res.tx_block   = i_item.rx_block;
                        o_res.file_close = w_wr_short;
                    end else begin
                        o_res.tx_kind  = KIND_ERR;
                        o_res.tx_error = ERR_DISK_FULL;
                    end
                end
            end
            default: begin
                o_res.port_action = PORT_LISTEN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_INIT;
            r_block_counter <= 16'd0;
            r_last_block    <= 1'b0;
        end else if (i_adv) begin
            r_phase         <= n_phase;
            r_block_counter <= n_block_counter;
            r_last_block    <= n_last_block;
        end
    end

endmodule

`default_nettype wire

// ----- design/tftp_server_transfer_control_top.sv -----
// Top level of the TFTP server transfer controller: input/result registers and
// the APB register port. Depends on tftpc_pkg and tftpc_ctrl.
`default_nettype none

// Usage
// -----
// One input item per poll: the decoded received packet plus the file store's
// answers. Every item gives exactly one result item: the packet to send, file
// close and port commands, and the phase after the step.
// Input channel: i_valid / o_stall / i_item. Result channel: o_valid / i_stall /
// o_item. An item moves at a clock edge where valid is high and stall is low.
// An accepted item passes the input register, then the result register, and
// is offered from the result register. Throughput: one item per cycle while the
// receiver does not stall; the transfer state is updated in the same cycle the
// item passes from the input register to the result register, so the next item
// sees it straight away.
// Stalling: a held result stays put; the input register still takes one more
// item, and o_stall rises only once both registers are full.
// Reset (i_rst_n low, synchronous): both registers empty, phase init, block
// counter and last-block flag clear, listen_port back to 69.
// APB: listen_port at byte address 0, written in the access phase; pready is
// always high. Write it only while no item is in flight.

module tftp_server_transfer_control_top
    import tftpc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // item input
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire t_in_item    i_item,
    // result output
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_out_item        o_item,
    // APB register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    t_out_item   r_out;
    logic [15:0] r_listen_port;

    logic        w_out_free;
    logic        w_adv;
    logic        w_in_acc;
    logic        w_reg_sel;
    t_out_item   w_res;

    // Result register can take a new item when empty or being drained.
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_adv      = r_in_valid && w_out_free;
    assign o_stall    = r_in_valid && !w_out_free;
    assign w_in_acc   = i_valid && !o_stall;

    tftpc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_item  (r_in),
        .o_res   (w_res)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= i_item;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // Register port: word index is paddr[2]
    assign w_reg_sel = paddr[2] == REG_LISTEN_PORT;
    assign pready    = 1'b1;
    assign prdata    = w_reg_sel ? {16'd0, r_listen_port} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_listen_port <= LISTEN_PORT_RESET;
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_listen_port <= pwdata[15:0];
        end
    end

endmodule

`default_nettype wire

// ----- tb/sv/tftpc_xfer_check_pkg.sv -----
// Scoreboard for the TFTP transfer controller: predicts each reply item.
// Depends on tftpc_pkg for the item structs, phase enum and protocol codes.
`timescale 1ns / 1ps

package tftpc_xfer_check_pkg;

    import tftpc_pkg::*;

    class xfer_scoreboard;

        // predicted controller state
        t_phase      phase;
        logic [15:0] blk_count;
        bit          last_blk;
        bit          peer_open;
        logic [15:0] listen_port;

        t_out_item   expected_replies[$];
        int unsigned mismatches;

        function new();
            phase       = PH_INIT;
            blk_count   = '0;
            last_blk    = 1'b0;
            peer_open   = 1'b0;
            listen_port = LISTEN_PORT_RESET;
            mismatches  = 0;
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10) begin
                $display("[%0t] MISMATCH: %s", $realtime, what);
            end
        endfunction

        function string fmt(t_out_item r);
            return $sformatf("kind=%0d blk=%0d err=%0d len=%0d close=%0d port=%0d phase=%0d",
                             r.tx_kind, r.tx_block, r.tx_error, r.tx_data_length,
                             r.file_close, r.port_action, r.phase_now);
        endfunction

        // next DATA block of a read; short block marks the end
        function void send_block(input logic [9:0] rlen, inout t_out_item r);
            logic [9:0] n;
            n = (rlen > BLOCK_BYTES) ? 10'(BLOCK_BYTES) : rlen;
            blk_count        = blk_count + 16'd1;
            r.tx_kind        = KIND_DATA;
            r.tx_block       = blk_count;
            r.tx_data_length = n;
            last_blk         = (n < BLOCK_BYTES);
            if (last_blk) begin
                r.file_close = 1'b1;
            end
            phase = PH_RD_ACK;
        endfunction

        function void send_ack(inout t_out_item r);
            r.tx_kind  = KIND_ACK;
            r.tx_block = blk_count;
            phase      = last_blk ? PH_INIT : PH_WR_DATA;
        endfunction

        // one poll: queue its reply, return whether the item had any effect
        function bit note_poll(t_in_item it);
            t_out_item   r;
            t_phase      was;
            logic [10:0] dlen;
            logic [2:0]  code;
            bit          refuse;
            r      = '0;
            was    = phase;
            refuse = 1'b1;
            code   = ERR_OTHER;
            case (phase)
                PH_WAIT_RQ: begin
                    if (it.rx_length > MIN_REQ_BYTES) begin
                        if (it.rx_opcode != OP_RRQ && it.rx_opcode != OP_WRQ) begin
                            code = ERR_ILLEGAL;
                        end else if (it.name_length < 1 || it.name_length > NAME_MAX) begin
                            code = ERR_OTHER;
                        end else if (it.transfer_mode != MODE_OCTET &&
                                     it.transfer_mode != MODE_NETASCII) begin
                            code = ERR_ILLEGAL;
                        end else if (!it.file_ok) begin
                            code = (it.rx_opcode == OP_RRQ) ? ERR_NO_FILE : ERR_ACCESS;
                        end else begin
                            refuse        = 1'b0;
                            r.port_action = PORT_PEER;
                            peer_open     = 1'b1;
                            if (it.rx_opcode == OP_RRQ) begin
                                send_block(it.read_length, r);
                            end else begin
                                send_ack(r);
                            end
                        end
                        if (refuse) begin
                            r.tx_kind  = KIND_ERR;
                            r.tx_error = code;
                        end
                    end
                end
                PH_RD_SEND: send_block(it.read_length, r);
                PH_RD_ACK: begin
                    if (it.rx_length == ACK_BYTES && it.rx_opcode == OP_ACK &&
                        it.rx_block == blk_count) begin
                        phase = last_blk ? PH_INIT : PH_RD_SEND;
                    end
                end
                PH_WR_ACK: send_ack(r);
                PH_WR_DATA: begin
                    if (it.rx_length >= HDR_BYTES && it.rx_length <= BLOCK_BYTES + HDR_BYTES &&
                        it.rx_opcode == OP_DATA) begin
                        dlen      = it.rx_length - 11'(HDR_BYTES);
                        blk_count = it.rx_block;
                        if ({1'b0, it.write_length} == dlen) begin
                            if (dlen < BLOCK_BYTES) begin
                                last_blk     = 1'b1;
                                r.file_close = 1'b1;
                            end
                            send_ack(r);
                        end else begin
                            r.tx_kind  = KIND_ERR;
                            r.tx_error = ERR_DISK_FULL;
                            phase      = PH_INIT;
                        end
                    end
                end
                default: begin
                    peer_open     = 1'b0;
                    r.port_action = PORT_LISTEN;
                    blk_count     = '0;
                    last_blk      = 1'b0;
                    phase         = PH_WAIT_RQ;
                end
            endcase
            r.phase_now = phase;
            expected_replies.push_back(r);
            return (r.tx_kind != KIND_NONE) || (r.port_action != PORT_NONE) || (phase != was);
        endfunction

        function void check_reply(t_out_item got);
            t_out_item exp;
            string     diff;
            if (expected_replies.size() == 0) begin
                flag({"reply with no poll outstanding: ", fmt(got)});
                return;
            end
            exp  = expected_replies.pop_front();
            diff = "";
            if (got.tx_kind !== exp.tx_kind)               diff = {diff, " tx_kind"};
            if (got.tx_block !== exp.tx_block)             diff = {diff, " tx_block"};
            if (got.tx_error !== exp.tx_error)             diff = {diff, " tx_error"};
            if (got.tx_data_length !== exp.tx_data_length) diff = {diff, " tx_data_length"};
            if (got.file_close !== exp.file_close)         diff = {diff, " file_close"};
            if (got.port_action !== exp.port_action)       diff = {diff, " port_action"};
            if (got.phase_now !== exp.phase_now)           diff = {diff, " phase_now"};
            if (diff != "") begin
                flag({"field(s)", diff, "\n  expected ", fmt(exp), "\n  actual   ", fmt(got)});
            end
        endfunction

    endclass

endpackage

// ----- tb/sv/tb_top.sv -----
// Top-level testbench for tftp_server_transfer_control_top: drives polls and APB
// writes, checks every reply item. Depends on tftpc_pkg and tftpc_xfer_check_pkg.
`timescale 1ns / 1ps

module tb_top;

    import tftpc_pkg::*;
    import tftpc_xfer_check_pkg::*;

    // Mode and opcode values with no name in the design package
    localparam logic [1:0]  MODE_OTHER    = 2'd2;
    localparam logic [1:0]  MODE_RESERVED = 2'd3;
    localparam logic [15:0] OP_UNKNOWN    = 16'hFFFF;

    localparam int unsigned HOLD_CYCLES    = 60;   // long receiver hold-off
    localparam int unsigned WATCHDOG_LIMIT = 1000; // quiet cycles before giving up
    localparam int unsigned RESET_CYCLES   = 11;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in_item    i_item;
    logic        o_valid;
    logic        i_stall;
    t_out_item   o_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    xfer_scoreboard sb = new();

    bit          send_idle    = 1'b1; // sender gaps on/off, reshuffled per burst
    bit          hold_request = 1'b0; // asks the receiver for one long hold-off
    int unsigned quiet_cycles = 0;

    tftp_server_transfer_control_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Watchdog: a run with nothing moving for too long has hung
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid === 1'b1 && !i_stall) || !i_rst_n ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tftp_server_transfer_control_top test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------

    function automatic t_in_item mk(int unsigned len, logic [15:0] op, int unsigned blk,
                                    int unsigned nlen, logic [1:0] mode, bit ok,
                                    int unsigned rlen, int unsigned wlen);
        t_in_item it;
        it.rx_length     = 11'(len);
        it.rx_opcode     = op;
        it.rx_block      = 16'(blk);
        it.name_length   = 8'(nlen);
        it.transfer_mode = mode;
        it.file_ok       = ok;
        it.read_length   = 10'(rlen);
        it.write_length  = 10'(wlen);
        return it;
    endfunction

    // Block size from the file store: mostly full blocks so transfers run on,
    // sometimes short ones to end them, now and then beyond the 512 limit
    function automatic logic [9:0] pick_block_len();
        int unsigned pick;
        pick = $urandom_range(0, 7);
        if (pick < 6) begin
            return 10'(BLOCK_BYTES);
        end else if (pick == 6) begin
            return 10'($urandom_range(0, BLOCK_BYTES - 1));
        end
        return 10'($urandom_range(0, 1023));
    endfunction

    // Next poll, shaped by the predicted phase so that most of them drive a
    // transfer forward; the rest are unshaped noise over all bits
    function automatic t_in_item shape_poll();
        logic [95:0] raw;
        t_in_item    it;
        logic [9:0]  dlen;
        raw = {$urandom, $urandom, $urandom};
        it  = raw[$bits(t_in_item)-1:0];
        if ($urandom_range(0, 9) < 2) begin
            return it;
        end
        case (sb.phase)
            PH_WAIT_RQ: begin
                it.rx_length = 11'($urandom_range(MIN_REQ_BYTES + 1, 80));
                it.rx_opcode = ($urandom_range(0, 1) != 0) ? OP_RRQ : OP_WRQ;
                if ($urandom_range(0, 15) != 0) begin
                    it.name_length = 8'($urandom_range(1, NAME_MAX));
                end
                if ($urandom_range(0, 15) != 0) begin
                    it.transfer_mode = ($urandom_range(0, 1) != 0) ? MODE_OCTET : MODE_NETASCII;
                end
                it.file_ok     = ($urandom_range(0, 9) != 0);
                it.read_length = pick_block_len();
            end
            PH_RD_SEND: it.read_length = pick_block_len();
            PH_RD_ACK: begin
                it.rx_length = 11'(ACK_BYTES);
                it.rx_opcode = OP_ACK;
                // occasional duplicate of the previous ack
                it.rx_block  = ($urandom_range(0, 7) == 0) ? sb.blk_count - 16'd1 : sb.blk_count;
            end
            PH_WR_DATA: begin
                dlen         = pick_block_len();
                it.rx_length = 11'(dlen) + 11'(HDR_BYTES);
                it.rx_opcode = OP_DATA;
                if ($urandom_range(0, 15) != 0) begin
                    it.rx_block = sb.blk_count + 16'd1;
                end
                if ($urandom_range(0, 9) != 0) begin
                    it.write_length = dlen;
                end
            end
            default: ;
        endcase
        return it;
    endfunction

    // Offer one poll after a random gap; note it once taken
    task automatic send_poll(input t_in_item it, output bit acted);
        int unsigned gap;
        gap = send_idle ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_stall);
        acted = sb.note_poll(it);
    endtask

    // The given number of random polls
    task automatic run_polls(input int unsigned count);
        int unsigned sent;
        bit          acted;
        sent = 0;
        while (sent < count) begin
            if (sent % 64 == 0) begin
                send_idle = ($urandom_range(0, 3) != 0);
            end
            send_poll(shape_poll(), acted);
            sent++;
        end
    endtask

    // Wait for all replies, then let the pipeline settle before a register access
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.expected_replies.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic read_listen_port();
        logic [31:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {REG_LISTEN_PORT, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        forever begin
            @(negedge i_clk);
            rd = prdata;
            @(posedge i_clk);
            if (pready) break;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[15:0] !== sb.listen_port) begin
            sb.flag($sformatf("listen_port read back %0d, expected %0d", rd[15:0],
                              sb.listen_port));
        end
    endtask

    // Write listen_port (junk in the upper bits) and read it back
    task automatic set_listen_port(input logic [15:0] port);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_LISTEN_PORT, 2'b00};
        pwdata  <= {16'($urandom), port};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.listen_port = port;
        read_listen_port();
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall per reply, bursts without stalls, and one long
    // hold-off on request; every reply taken is checked
    // ------------------------------------------------------------------
    initial begin
        int unsigned hold;
        int unsigned taken;
        bit          recv_idle;
        recv_idle = 1'b1;
        taken     = 0;
        i_stall <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                hold         = HOLD_CYCLES;
            end else begin
                hold = recv_idle ? $urandom_range(0, 7) : 0;
            end
            if (hold != 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid === 1'b1 && !i_stall));
            sb.check_reply(o_item);
            taken++;
            if (taken % 50 == 0) begin
                recv_idle = ($urandom_range(0, 3) != 0);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        bit acted;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_item  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        read_listen_port();   // reset value
        @(posedge i_clk);
        set_listen_port(16'd1);

        // Directed: request checks in order, one read and two writes
        send_poll(mk(0, OP_RRQ, 0, 0, MODE_OCTET, 0, 0, 0), acted);            // init: listen
        send_poll(mk(ACK_BYTES, OP_RRQ, 0, 8, MODE_OCTET, 1, 512, 0), acted);   // too short
        send_poll(mk(2047, OP_UNKNOWN, 16'hFFFF, 255, MODE_RESERVED, 1, 1023, 1023), acted);
        send_poll(mk(20, OP_RRQ, 0, 0, MODE_OCTET, 1, 512, 0), acted);          // empty name
        send_poll(mk(20, OP_WRQ, 0, NAME_MAX + 1, MODE_OCTET, 1, 0, 0), acted); // name too long
        send_poll(mk(20, OP_RRQ, 0, NAME_MAX, MODE_OTHER, 1, 512, 0), acted);   // bad mode
        send_poll(mk(20, OP_WRQ, 0, 1, MODE_RESERVED, 1, 0, 0), acted);
        send_poll(mk(20, OP_RRQ, 0, 1, MODE_OCTET, 0, 512, 0), acted);          // no such file
        send_poll(mk(20, OP_WRQ, 0, 1, MODE_NETASCII, 0, 0, 0), acted);         // create refused
        send_poll(mk(20, OP_RRQ, 0, NAME_MAX, MODE_NETASCII, 1, 512, 0), acted);// read: DATA 1
        send_poll(mk(ACK_BYTES, OP_ACK, 2, 0, MODE_OCTET, 0, 0, 0), acted);     // wrong block
        send_poll(mk(ACK_BYTES + 1, OP_ACK, 1, 0, MODE_OCTET, 0, 0, 0), acted); // wrong length
        send_poll(mk(ACK_BYTES, OP_ACK, 1, 0, MODE_OCTET, 0, 0, 0), acted);
        send_poll(mk(0, OP_RRQ, 0, 0, MODE_OCTET, 0, 1023, 0), acted);          // saturates
        send_poll(mk(ACK_BYTES, OP_ACK, 2, 0, MODE_OCTET, 0, 0, 0), acted);
        send_poll(mk(2047, OP_ACK, 0, 0, MODE_OCTET, 0, 511, 0), acted);        // short: close
        send_poll(mk(ACK_BYTES, OP_ACK, 3, 0, MODE_OCTET, 0, 0, 0), acted);     // read done
        send_poll(mk(0, OP_RRQ, 0, 0, MODE_OCTET, 0, 0, 0), acted);
        send_poll(mk(MIN_REQ_BYTES + 1, OP_WRQ, 0, 1, MODE_OCTET, 1, 0, 0), acted); // ACK 0
        send_poll(mk(HDR_BYTES - 1, OP_DATA, 1, 0, MODE_OCTET, 0, 0, 0), acted);    // runt
        send_poll(mk(BLOCK_BYTES + HDR_BYTES + 1, OP_DATA, 1, 0, MODE_OCTET, 0, 0, 512), acted);
        send_poll(mk(100, OP_ACK, 1, 0, MODE_OCTET, 0, 0, 96), acted);          // not DATA
        send_poll(mk(BLOCK_BYTES + HDR_BYTES, OP_DATA, 16'hFFFF, 0, MODE_OCTET, 0, 0, 512),
                  acted);
        send_poll(mk(HDR_BYTES, OP_DATA, 0, 0, MODE_OCTET, 0, 0, 0), acted);    // empty last
        send_poll(mk(0, OP_RRQ, 0, 0, MODE_OCTET, 0, 0, 0), acted);
        send_poll(mk(9, OP_WRQ, 0, NAME_MAX, MODE_NETASCII, 1, 0, 0), acted);
        send_poll(mk(100, OP_DATA, 1, 0, MODE_OCTET, 0, 0, 1023), acted);       // disk full
        drain();

        set_listen_port(16'hFFFF);
        run_polls(600);
        drain();

        // Second phase asks for a long receiver hold-off before each of its two runs so the block fills
        set_listen_port(16'($urandom_range(1, 65535)));
        hold_request = 1'b1;
        run_polls(300);
        hold_request = 1'b1;
        run_polls(300);
        drain();

        set_listen_port(LISTEN_PORT_RESET);
        run_polls(520);
        drain();
        repeat (8) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.expected_replies.size() == 0) begin
            $display("tftp_server_transfer_control_top test passed");
        end else begin
            $display("tftp_server_transfer_control_top test failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/tftpc_pkg.sv
design/tftpc_ctrl.sv
design/tftp_server_transfer_control_top.sv
tb/sv/tftpc_xfer_check_pkg.sv
tb/sv/tb_top.sv
